FILE: design/frontier_cell_classifier_macros.svh
// ---------------------------------------------------------------------------
// frontier cell classifier assertion macros
// concurrent checks on the block's own control, removed with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef FRONTIER_CELL_CLASSIFIER_MACROS_SVH
`define FRONTIER_CELL_CLASSIFIER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define FCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcc check failed");

// next-cycle implication
`define FCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcc check failed");

`else

`define FCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/fcc_pkg.sv
// ---------------------------------------------------------------------------
// fcc_pkg
// types, codes and the 3x3 neighbour table of the frontier cell classifier
// ---------------------------------------------------------------------------
`default_nettype none

package fcc_pkg;

  // request kinds carried on the slave tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRONG_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRONTIER_THR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_LIM  = 3'd4;

  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [7:0] CELL_UNKNOWN = 8'hFF;

  // neighbour walk
  localparam logic [2:0] NBR_FIRST = 3'd0;
  localparam logic [2:0] NBR_LAST  = 3'd7;

  typedef enum logic [2:0] {
    CLS_BORDER      = 3'd0,
    CLS_STRONG_EDGE = 3'd1,
    CLS_FRONTIER    = 3'd2,
    CLS_UNKNOWN     = 3'd3,
    CLS_INTERIOR    = 3'd4
  } class_e;

  // offset of one neighbour and its sobel weights
  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic signed [2:0] wx;
    logic signed [2:0] wy;
  } nbr_t;

  // top is row y+1, right is column x+1
  function automatic nbr_t nbr_of(logic [2:0] k);
    nbr_t n;
    unique case (k)
      3'd0:    n = '{dx: -2'sd1, dy:  2'sd1, wx: -3'sd1, wy:  3'sd1}; // top left
      3'd1:    n = '{dx:  2'sd0, dy:  2'sd1, wx:  3'sd0, wy:  3'sd2}; // top
      3'd2:    n = '{dx:  2'sd1, dy:  2'sd1, wx:  3'sd1, wy:  3'sd1}; // top right
      3'd3:    n = '{dx: -2'sd1, dy:  2'sd0, wx: -3'sd2, wy:  3'sd0}; // left
      3'd4:    n = '{dx:  2'sd1, dy:  2'sd0, wx:  3'sd2, wy:  3'sd0}; // right
      3'd5:    n = '{dx: -2'sd1, dy: -2'sd1, wx: -3'sd1, wy: -3'sd1}; // bottom left
      3'd6:    n = '{dx:  2'sd0, dy: -2'sd1, wx:  3'sd0, wy: -3'sd2}; // bottom
      default: n = '{dx:  2'sd1, dy: -2'sd1, wx:  3'sd1, wy: -3'sd1}; // bottom right
    endcase
    return n;
  endfunction

  // absolute value of a signed byte, 128 stays representable
  function automatic logic [7:0] magnitude(logic [7:0] v);
    return v[7] ? 8'(-v) : v;
  endfunction

  // magnitude times a weight of -2..2
  function automatic logic signed [10:0] weigh(logic [7:0] m, logic signed [2:0] w);
    logic signed [10:0] base;
    base = (w == 3'sd2 || w == -3'sd2) ? signed'(11'({m, 1'b0})) : signed'(11'(m));
    if (w == 3'sd0) begin
      return '0;
    end
    return (w < 3'sd0) ? -base : base;
  endfunction

endpackage

`default_nettype wire

FILE: design/frontier_cell_classifier.sv
// ---------------------------------------------------------------------------
// frontier_cell_classifier
// occupancy grid in one synchronous memory, sobel based frontier test of a cell
// ---------------------------------------------------------------------------
// usage
//   slave stream: tuser selects a cell write or a cell query, tdata holds
//   column, row and value. a write gives no result.
//   a query on or beyond the grid border gives no result either.
//   an interior query walks its eight neighbours through the single read port
//   of the grid memory, one a cycle, then decides: the result is loaded into
//   the output register once that register is free, and the next request is
//   taken in the cycle after that.
//   master stream: tuser holds class code and excluded flag, tdata the
//   gradient sum and the unknown neighbour count.
//   the output register parts the sides: a stalled result does not block new
//   writes or a new query; only the decision of a following query waits.
//   reset restores the register defaults and empties the pipeline; grid
//   contents are undefined until written, a query must only touch written
//   cells. configuration writes must go in while the block is idle (unchecked).
// ---------------------------------------------------------------------------
`default_nettype none

`include "frontier_cell_classifier_macros.svh"

module frontier_cell_classifier
  import fcc_pkg::*;
#(
  parameter int unsigned GRID_SIDE_MAX = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // request stream
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [23:0]           s_axis_tdata_i,  // cell_x, cell_y, cell_value
  input  wire logic                  s_axis_tuser_i,  // opcode
  // result stream
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [15:0]                m_axis_tdata_o,  // gradient_sum, unknown_neighbours, pad
  output logic [3:0]                 m_axis_tuser_o   // class_code, excluded
);

  localparam int unsigned DEPTH  = GRID_SIDE_MAX * GRID_SIDE_MAX;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned SIDE_W = $clog2(GRID_SIDE_MAX + 1);
  localparam int unsigned CMP_W  = (SIDE_W > 9) ? SIDE_W : 9;
  localparam logic [CMP_W-1:0] SIDE_LIM = CMP_W'(GRID_SIDE_MAX);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_DECIDE
  } state_e;

  // configuration registers
  logic [8:0] grid_width_q, grid_height_q;
  logic [9:0] strong_thr_q, frontier_thr_q;
  logic [3:0] unknown_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q   <= 9'd256;
      grid_height_q  <= 9'd256;
      strong_thr_q   <= 10'd8;
      frontier_thr_q <= 10'd4;
      unknown_lim_q  <= 4'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_GRID_WIDTH:   grid_width_q   <= cfg_data_i[8:0];
        REG_GRID_HEIGHT:  grid_height_q  <= cfg_data_i[8:0];
        REG_STRONG_THR:   strong_thr_q   <= cfg_data_i;
        REG_FRONTIER_THR: frontier_thr_q <= cfg_data_i;
        REG_UNKNOWN_LIM:  unknown_lim_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // geometry clipped to the memory size
  logic [CMP_W-1:0] eff_w, eff_h;
  assign eff_w = (CMP_W'(grid_width_q) > SIDE_LIM) ? SIDE_LIM : CMP_W'(grid_width_q);
  assign eff_h = (CMP_W'(grid_height_q) > SIDE_LIM) ? SIDE_LIM : CMP_W'(grid_height_q);

  // request fields
  logic [7:0] in_x, in_y, in_value;
  logic       in_acc;
  logic       in_inside, in_border;
  assign in_x     = s_axis_tdata_i[7:0];
  assign in_y     = s_axis_tdata_i[15:8];
  assign in_value = s_axis_tdata_i[23:16];
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;

  assign in_inside = (CMP_W'(in_x) < eff_w) && (CMP_W'(in_y) < eff_h);
  assign in_border = (in_x == 8'd0) || (in_y == 8'd0) ||
                     (CMP_W'(in_x) + CMP_W'(1) >= eff_w) ||
                     (CMP_W'(in_y) + CMP_W'(1) >= eff_h);

  // control and payload registers
  state_e            state_q, state_d;
  logic [7:0]        x_q, x_d, y_q, y_d;
  logic [2:0]        iss_q, iss_d;
  logic [2:0]        ret_idx_q, ret_idx_d;
  logic              rd_pend_q, rd_pend_d;
  logic signed [10:0] gx_q, gx_d, gy_q, gy_d;
  logic [3:0]        unk_q, unk_d;
  logic              m_valid_q, m_valid_d;
  class_e            cls_q, cls_d;
  logic              exc_q, exc_d;
  logic [9:0]        grad_q, grad_d;
  logic [3:0]        unk_out_q, unk_out_d;

  // grid memory
  logic [7:0]        mem [DEPTH];
  logic              mem_we, rd_en;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        rdata_q;

  nbr_t       iss_nbr, ret_nbr;
  logic [8:0] nx, ny;
  assign iss_nbr = nbr_of(iss_q);
  assign ret_nbr = nbr_of(ret_idx_q);
  assign nx      = 9'(x_q) + 9'(iss_nbr.dx);
  assign ny      = 9'(y_q) + 9'(iss_nbr.dy);

  assign mem_we = in_acc && (s_axis_tuser_i == OP_WRITE) && in_inside;
  assign waddr  = ADDR_W'(32'(in_y) * GRID_SIDE_MAX) + ADDR_W'(in_x);
  assign rd_en  = (state_q == ST_READ);
  assign raddr  = ADDR_W'(32'(ny) * GRID_SIDE_MAX) + ADDR_W'(nx);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= in_value;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  // decision on the finished sums
  logic [10:0] abs_gx, abs_gy, sum;
  logic        out_free;
  assign abs_gx   = gx_q[10] ? 11'(-gx_q) : 11'(gx_q);
  assign abs_gy   = gy_q[10] ? 11'(-gy_q) : 11'(gy_q);
  assign sum      = abs_gx + abs_gy;
  assign out_free = !m_valid_q || m_axis_tready_i;

  logic [7:0] rd_mag;
  assign rd_mag = magnitude(rdata_q);

  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    y_d       = y_q;
    iss_d     = iss_q;
    ret_idx_d = ret_idx_q;
    rd_pend_d = 1'b0;
    gx_d      = gx_q;
    gy_d      = gy_q;
    unk_d     = unk_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    cls_d     = cls_q;
    exc_d     = exc_q;
    grad_d    = grad_q;
    unk_out_d = unk_out_q;

    // neighbour returning from memory
    if (rd_pend_q) begin
      gx_d  = gx_q + weigh(rd_mag, ret_nbr.wx);
      gy_d  = gy_q + weigh(rd_mag, ret_nbr.wy);
      unk_d = unk_q + 4'((rdata_q == CELL_UNKNOWN));
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser_i == OP_QUERY) && !in_border) begin
          x_d     = in_x;
          y_d     = in_y;
          iss_d   = NBR_FIRST;
          gx_d    = '0;
          gy_d    = '0;
          unk_d   = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        rd_pend_d = 1'b1;
        ret_idx_d = iss_q;
        iss_d     = iss_q + 3'd1;
        if (iss_q == NBR_LAST) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          grad_d    = (sum > 11'd1023) ? 10'h3FF : sum[9:0];
          unk_out_d = unk_q;
          if (sum > 11'(strong_thr_q)) begin
            cls_d = CLS_STRONG_EDGE;
            exc_d = 1'b1;
          end else if (sum >= 11'(frontier_thr_q)) begin
            cls_d = CLS_FRONTIER;
            exc_d = 1'b0;
          end else if (unk_q > unknown_lim_q) begin
            cls_d = CLS_UNKNOWN;
            exc_d = 1'b0;
          end else begin
            cls_d = CLS_INTERIOR;
            exc_d = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      x_q       <= '0;
      y_q       <= '0;
      iss_q     <= '0;
      ret_idx_q <= '0;
      rd_pend_q <= 1'b0;
      gx_q      <= '0;
      gy_q      <= '0;
      unk_q     <= '0;
      m_valid_q <= 1'b0;
      cls_q     <= CLS_BORDER;
      exc_q     <= 1'b0;
      grad_q    <= '0;
      unk_out_q <= '0;
    end else begin
      state_q   <= state_d;
      x_q       <= x_d;
      y_q       <= y_d;
      iss_q     <= iss_d;
      ret_idx_q <= ret_idx_d;
      rd_pend_q <= rd_pend_d;
      gx_q      <= gx_d;
      gy_q      <= gy_d;
      unk_q     <= unk_d;
      m_valid_q <= m_valid_d;
      cls_q     <= cls_d;
      exc_q     <= exc_d;
      grad_q    <= grad_d;
      unk_out_q <= unk_out_d;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, unk_out_q, grad_q};
  assign m_axis_tuser_o  = {exc_q, cls_q};

  // checks
  `FCC_ASSERT_NEXT(a_query_starts_walk, clk_i, rst_ni, in_acc && s_axis_tuser_i == OP_QUERY && !in_border, state_q == ST_READ && iss_q == NBR_FIRST)
  `FCC_ASSERT_IMPL(a_pending_read_in_walk, clk_i, rst_ni, rd_pend_q, state_q == ST_READ || state_q == ST_LAST)
  `FCC_ASSERT_IMPL(a_last_is_final_nbr, clk_i, rst_ni, state_q == ST_LAST, rd_pend_q && ret_idx_q == NBR_LAST)
  `FCC_ASSERT_NEXT(a_decide_waits_stall, clk_i, rst_ni, state_q == ST_DECIDE && m_valid_q && !m_axis_tready_i, state_q == ST_DECIDE && m_valid_q)

endmodule

`default_nettype wire

FILE: tb/sv/tb_frontier_cell_classifier.sv
// ---------------------------------------------------------------------------
// tb_frontier_cell_classifier
// stream level check of the frontier cell classifier: cell writes and cell
// queries go in through the request stream under several grid sizes and
// threshold settings; an in-bench copy of the grid predicts every verdict,
// and each result is compared field by field with the oldest prediction
// ---------------------------------------------------------------------------
module tb_frontier_cell_classifier
  import fcc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE_MAX    = 256;
  localparam int DRAIN_CYCLE = 24;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 112;

  typedef struct packed {
    logic       opcode;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic [7:0] cell_value;
  } cell_request_t;

  typedef struct packed {
    class_e     class_code;
    logic       excluded;
    logic [9:0] gradient_sum;
    logic [3:0] unknown_neighbours;
  } verdict_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [23:0]           s_axis_tdata_i = '0;  // cell_x, cell_y, cell_value
  logic                  s_axis_tuser_i = 1'b0; // opcode
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [15:0]           m_axis_tdata_o;        // gradient_sum, unknown_neighbours, pad
  logic [3:0]            m_axis_tuser_o;        // class_code, excluded

  frontier_cell_classifier dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // mirror of the block's registers and grid
  int grid_w       = 256;
  int grid_h       = 256;
  int strong_thr   = 8;
  int frontier_thr = 4;
  int unknown_lim  = 2;
  logic [7:0] occupancy [0:SIDE_MAX*SIDE_MAX-1];

  // cells loaded so far, tracked in generation order
  bit cell_loaded [0:SIDE_MAX*SIDE_MAX-1];

  cell_request_t cell_requests[$];
  verdict_t      expected_verdicts[$];
  cell_request_t held_req;
  bit            steady_mode = 1'b0;
  int            errors = 0;
  int            results_seen = 0;
  int            hold_left = 0;
  bit            hold_done = 1'b0;
  int            stall_cycles = 0;

  function automatic int side(int v);
    return (v > SIDE_MAX) ? SIDE_MAX : v;
  endfunction

  function automatic bit on_border(int x, int y);
    return x <= 0 || x >= side(grid_w) - 1 || y <= 0 || y >= side(grid_h) - 1;
  endfunction

  function automatic bit in_grid(int x, int y);
    return x < side(grid_w) && y < side(grid_h);
  endfunction

  function automatic int cell_mag(int x, int y);
    logic signed [7:0] v;
    v = occupancy[y*SIDE_MAX + x];
    return (v < 0) ? -int'(v) : int'(v);
  endfunction

  // sobel verdict of one cell, or a stored write
  task automatic classify_cell(input cell_request_t req);
    int x, y, gx, gy, sum, unk;
    verdict_t v;
    x = req.cell_x;
    y = req.cell_y;
    if (req.opcode == OP_WRITE) begin
      if (in_grid(x, y)) occupancy[y*SIDE_MAX + x] = req.cell_value;
    end else if (!on_border(x, y)) begin
      gx = -cell_mag(x-1, y+1) + cell_mag(x+1, y+1) - cell_mag(x-1, y-1)
           + cell_mag(x+1, y-1) - 2*cell_mag(x-1, y) + 2*cell_mag(x+1, y);
      gy = cell_mag(x-1, y+1) + cell_mag(x+1, y+1) - cell_mag(x-1, y-1)
           - cell_mag(x+1, y-1) + 2*cell_mag(x, y+1) - 2*cell_mag(x, y-1);
      sum = ((gx < 0) ? -gx : gx) + ((gy < 0) ? -gy : gy);
      unk = 0;
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          if ((dx != 0 || dy != 0) && occupancy[(y+dy)*SIDE_MAX + x + dx] == CELL_UNKNOWN)
            unk++;
        end
      end
      // strong edge wins whatever the threshold order
      if (sum > strong_thr) begin
        v.class_code = CLS_STRONG_EDGE;
        v.excluded = 1'b1;
      end else if (sum >= frontier_thr) begin
        v.class_code = CLS_FRONTIER;
        v.excluded = 1'b0;
      end else if (unk > unknown_lim) begin
        v.class_code = CLS_UNKNOWN;
        v.excluded = 1'b0;
      end else begin
        v.class_code = CLS_INTERIOR;
        v.excluded = 1'b1;
      end
      v.gradient_sum = (sum > 1023) ? 10'd1023 : 10'(sum);
      v.unknown_neighbours = 4'(unk);
      expected_verdicts = {expected_verdicts, v};
    end
  endtask

  function automatic logic [7:0] random_occupancy();
    int r;
    r = $urandom_range(99);
    if (r < 35) return CELL_UNKNOWN;
    if (r < 60) return 8'd0;
    if (r < 80) return 8'($urandom_range(3));
    if (r < 95) return 8'($urandom_range(100));
    return 8'($urandom_range(255));
  endfunction

  // one request queued; the cell counts as loaded when it lands inside the grid
  function automatic int queue_write(int x, int y, logic [7:0] value);
    cell_request_t req;
    req = '{opcode: OP_WRITE, cell_x: 8'(x), cell_y: 8'(y), cell_value: value};
    cell_requests = {cell_requests, req};
    if (in_grid(x, y)) begin
      cell_loaded[y*SIDE_MAX + x] = 1'b1;
    end
    return 1;
  endfunction

  // interior queries get their unloaded neighbours written first
  function automatic int queue_query(int x, int y, logic [7:0] value);
    int n;
    cell_request_t req;
    n = 0;
    if (!on_border(x, y)) begin
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          if ((dx != 0 || dy != 0) && !cell_loaded[(y+dy)*SIDE_MAX + x + dx])
            n += queue_write(x + dx, y + dy, random_occupancy());
        end
      end
    end
    n++;
    req = '{opcode: OP_QUERY, cell_x: 8'(x), cell_y: 8'(y), cell_value: value};
    cell_requests = {cell_requests, req};
    return n;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(value);
  endtask

  task automatic program_config(input int w, input int h, input int s, input int f,
                                input int u);
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_STRONG_THR, s);
    write_reg(REG_FRONTIER_THR, f);
    write_reg(REG_UNKNOWN_LIM, u);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    grid_w       = w & 'h1FF;
    grid_h       = h & 'h1FF;
    strong_thr   = s & 'h3FF;
    frontier_thr = f & 'h3FF;
    unknown_lim  = u & 'hF;
  endtask

  // idle means nothing pending for a full drain window
  task automatic wait_idle();
    int quiet;
    quiet = 0;
    while (quiet < DRAIN_CYCLE) begin
      @(posedge clk_i);
      if (cell_requests.size() != 0 || s_axis_tvalid_i || expected_verdicts.size() != 0)
        quiet = 0;
      else
        quiet++;
    end
  endtask

  function automatic int pick_side();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 3;
    if (r < 20) return 256;
    if (r < 28) return $urandom_range(511, 257);
    if (r < 33) return $urandom_range(2);
    return $urandom_range(256, 3);
  endfunction

  function automatic int pick_threshold();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 0;
    if (r < 25) return 1023;
    if (r < 32) return 800;
    return $urandom_range(24);
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) classify_cell(held_req);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (cell_requests.size() != 0 && (steady_mode || $urandom_range(99) >= 22)) begin
          held_req = cell_requests.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {held_req.cell_value, held_req.cell_y, held_req.cell_x};
          s_axis_tuser_i  <= held_req.opcode;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        results_seen++;
        if (expected_verdicts.size() == 0) begin
          $error("result with no request waiting");
          errors++;
        end else begin
          exp_v = expected_verdicts.pop_front();
          if (m_axis_tuser_o[2:0] !== exp_v.class_code) begin
            $error("class_code expected %0d actual %0d", exp_v.class_code,
                   m_axis_tuser_o[2:0]);
            errors++;
          end
          if (m_axis_tuser_o[3] !== exp_v.excluded) begin
            $error("excluded expected %0d actual %0d", exp_v.excluded, m_axis_tuser_o[3]);
            errors++;
          end
          if (m_axis_tdata_o[9:0] !== exp_v.gradient_sum) begin
            $error("gradient_sum expected %0d actual %0d", exp_v.gradient_sum,
                   m_axis_tdata_o[9:0]);
            errors++;
          end
          if (m_axis_tdata_o[13:10] !== exp_v.unknown_neighbours) begin
            $error("unknown_neighbours expected %0d actual %0d",
                   exp_v.unknown_neighbours, m_axis_tdata_o[13:10]);
            errors++;
          end
        end
      end
      // one long hold-off so the block backs up into the request side
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else if (!hold_done && results_seen == 150) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= steady_mode || $urandom_range(99) >= 22;
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("tb_frontier_cell_classifier failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int ew, eh, rx0, ry0, r, done, tried;
    logic [7:0] ring [8];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part under reset defaults
    ring = '{CELL_UNKNOWN, CELL_UNKNOWN, CELL_UNKNOWN, CELL_UNKNOWN,
             CELL_UNKNOWN, CELL_UNKNOWN, CELL_UNKNOWN, CELL_UNKNOWN};
    done = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        if (dx != 0 || dy != 0) begin
          void'(queue_write(1 + dx, 1 + dy, ring[done]));
          done++;
        end
      end
    end
    // all eight neighbours unknown
    void'(queue_query(1, 1, 8'hFF));
    // strongest magnitudes on opposite corners
    void'(queue_write(0, 2, 8'sd127));
    void'(queue_write(2, 0, 8'h80));
    void'(queue_query(1, 1, 8'hAA));
    void'(queue_write(1, 2, 8'd100));
    void'(queue_query(1, 1, 8'h00));
    // border queries on every side
    void'(queue_query(0, 1, 8'h00));
    void'(queue_query(1, 0, 8'h00));
    void'(queue_query(255, 7, 8'h00));
    void'(queue_query(7, 255, 8'h00));
    void'(queue_write(255, 255, 8'd100));
    void'(queue_query(255, 255, 8'h00));

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: program_config(256, 256, 8, 4, 2);
        1: program_config(3, 3, 0, 0, 0);
        2: program_config(511, 300, 1023, 1023, 15);
        3: program_config(2, 511, 800, 0, 8);
        4: program_config(0, 0, 0, 1023, 0);
        5: program_config($urandom_range(40, 3), $urandom_range(40, 3), 6, 12, 3);
        default: program_config(pick_side(), pick_side(), pick_threshold(),
                                pick_threshold(),
                                ($urandom_range(9) == 0) ? 15 : $urandom_range(8));
      endcase
      steady_mode = (p == 5 || p == 6);
      ew = side(grid_w);
      eh = side(grid_h);
      rx0 = (ew > 8) ? $urandom_range(ew - 8) : 0;
      ry0 = (eh > 8) ? $urandom_range(eh - 8) : 0;
      done = 0;
      tried = 0;
      // mostly queries around one region, some writes there, the rest scattered noise
      while (done < PHASE_ITEMS && tried < 400) begin
        r = $urandom_range(99);
        tried++;
        if (r < 70) begin
          done += queue_query(rx0 + $urandom_range(7), ry0 + $urandom_range(7),
                              8'($urandom_range(255)));
        end else if (r < 85) begin
          done += queue_write(rx0 + $urandom_range(7), ry0 + $urandom_range(7),
                              random_occupancy());
        end else if ($urandom_range(1) == 0) begin
          done += queue_write($urandom_range(255), $urandom_range(255),
                              8'($urandom_range(255)));
        end else begin
          done += queue_query($urandom_range(255), $urandom_range(255),
                              8'($urandom_range(255)));
        end
      end
    end

    wait_idle();
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("tb_frontier_cell_classifier passed");
    end else begin
      $display("tb_frontier_cell_classifier failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/fcc_pkg.sv
design/frontier_cell_classifier.sv
tb/sv/tb_frontier_cell_classifier.sv
